[design/int8_linear_requant_top_macros.svh]
// ----------------------------------------------------------------------------
// int8_linear_requant_top_macros
// assertion macros shared by the requant block
// ----------------------------------------------------------------------------
`ifndef INT8_LINEAR_REQUANT_TOP_MACROS_SVH
`define INT8_LINEAR_REQUANT_TOP_MACROS_SVH

// checked only while out of reset
`define REQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define REQ_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/i8lrq_pkg.sv]
// ----------------------------------------------------------------------------
// i8lrq_pkg
// shared types and constants of the int8 linear requant block
// ----------------------------------------------------------------------------
`default_nettype none
package i8lrq_pkg;
	localparam int MAX_CHANNELS_DEF = 64;
	localparam int MAX_EMB_DEF      = 256;
	localparam int RESULT_CAP       = 64;
	localparam int CLIP_MAX         = 127;
	localparam int CLIP_MIN         = -128;
	localparam int CFG_W            = 16;
	localparam int CFG_IDX_W        = 3;
	localparam int QUEUE_DEPTH      = 4;

	typedef enum logic [1:0] {
		ACT_WEIGHT = 2'd0,
		ACT_BIAS   = 2'd1,
		ACT_ROW    = 2'd2
	} act_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EMB_LENGTH    = 3'd0,
		REG_HEAD_COUNT    = 3'd1,
		REG_PROJ_COUNT    = 3'd2,
		REG_SEQ_LENGTH    = 3'd3,
		REG_SCALE_MUL     = 3'd4,
		REG_REQUANT_SHIFT = 3'd5
	} reg_idx_t;

	typedef struct packed {
		act_t        op;
		logic [5:0]  channel;
		logic [7:0]  emb_index;
		logic [15:0] value;
		logic        trig;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;
endpackage
`default_nettype wire

[design/i8lrq_in_if.sv]
// ----------------------------------------------------------------------------
// i8lrq_in_if
// input item channel: loads and activation elements
// ----------------------------------------------------------------------------
`default_nettype none
interface i8lrq_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic [5:0]        channel;
	logic [7:0]        emb_index;
	logic signed [15:0] value;

	modport source (output valid, action, channel, emb_index, value, input ready);
	modport sink (input valid, action, channel, emb_index, value, output ready);
endinterface
`default_nettype wire

[design/i8lrq_out_if.sv]
// ----------------------------------------------------------------------------
// i8lrq_out_if
// result channel: one requantized value per channel and row
// ----------------------------------------------------------------------------
`default_nettype none
interface i8lrq_out_if;
	logic              valid;
	logic              ready;
	logic [5:0]        out_channel;
	logic [15:0]       seq_pos;
	logic signed [7:0] out_value;
	logic              last_of_row;

	modport source (output valid, out_channel, seq_pos, out_value, last_of_row, input ready);
	modport sink (input valid, out_channel, seq_pos, out_value, last_of_row, output ready);
endinterface
`default_nettype wire

[design/i8lrq_front.sv]
// ----------------------------------------------------------------------------
// i8lrq_front
// accepts input beats, drops out-of-range ones, flags the row end
// ----------------------------------------------------------------------------
`default_nettype none
module i8lrq_front #(
	parameter int MAX_CHANNELS = i8lrq_pkg::MAX_CHANNELS_DEF,
	parameter int MAX_EMB      = i8lrq_pkg::MAX_EMB_DEF,
	parameter int EW           = $clog2(MAX_EMB + 1)
) (
	i8lrq_in_if.sink        item,
	input  wire [EW-1:0]    elen,
	input  i8lrq_pkg::q_stat_t q_stat,
	output logic            push,
	output i8lrq_pkg::cmd_t cmd
);
	logic keep;
	logic ch_ok;
	logic ei_ok;

	assign item.ready = !q_stat.full;
	assign ch_ok = int'(item.channel) < MAX_CHANNELS;
	assign ei_ok = int'(item.emb_index) < MAX_EMB;

	always_comb begin
		unique case (item.action)
			i8lrq_pkg::ACT_WEIGHT: keep = ch_ok && ei_ok;
			i8lrq_pkg::ACT_BIAS:   keep = ch_ok;
			i8lrq_pkg::ACT_ROW:    keep = ei_ok;
			default:               keep = 1'b0;
		endcase
	end

	assign push = item.valid && item.ready && keep;

	always_comb begin
		cmd.op        = i8lrq_pkg::act_t'(item.action);
		cmd.channel   = item.channel;
		cmd.emb_index = item.emb_index;
		cmd.value     = item.value;
		// row end: element at the last effective position
		cmd.trig      = (item.action == i8lrq_pkg::ACT_ROW) &&
			(int'(item.emb_index) == int'(elen) - 1);
	end
endmodule
`default_nettype wire

[design/i8lrq_queue.sv]
// ----------------------------------------------------------------------------
// i8lrq_queue
// small command fifo between front and back
// ----------------------------------------------------------------------------
`default_nettype none
module i8lrq_queue #(
	parameter int DEPTH = i8lrq_pkg::QUEUE_DEPTH
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  i8lrq_pkg::cmd_t    push_cmd,
	input  wire                pop,
	output i8lrq_pkg::cmd_t    head,
	output i8lrq_pkg::q_stat_t stat
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	i8lrq_pkg::cmd_t  slot_q [DEPTH];
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    rp_q;
	logic [AW:0]      cnt_q;

	assign stat.full  = int'(cnt_q) == DEPTH;
	assign stat.empty = cnt_q == '0;
	assign head       = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (int'(wp_q) == DEPTH - 1) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (int'(rp_q) == DEPTH - 1) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

[design/i8lrq_back.sv]
// ----------------------------------------------------------------------------
// i8lrq_back
// store writes, per-channel mac loop, requantize and result register
// ----------------------------------------------------------------------------
`default_nettype none
module i8lrq_back #(
	parameter int MAX_CHANNELS = i8lrq_pkg::MAX_CHANNELS_DEF,
	parameter int MAX_EMB      = i8lrq_pkg::MAX_EMB_DEF,
	parameter int EW           = $clog2(MAX_EMB + 1),
	parameter int NW           = 7
) (
	input  wire                clk,
	input  wire                arst_n,
	input  i8lrq_pkg::cmd_t    cmd,
	input  wire                q_empty,
	output logic               pop,
	input  wire [EW-1:0]       elen,
	input  wire [NW-1:0]       nch,
	input  wire [15:0]         seq_length,
	input  wire signed [15:0]  scale_mul,
	input  wire [4:0]          requant_shift,
	i8lrq_out_if.source        result
);
	localparam int CH_CAP = (MAX_CHANNELS < i8lrq_pkg::RESULT_CAP) ?
		MAX_CHANNELS : i8lrq_pkg::RESULT_CAP;
	localparam int CIW    = (CH_CAP > 1) ? $clog2(CH_CAP) : 1;
	localparam int BAW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int EIW    = $clog2(MAX_EMB);
	localparam int WDEPTH = MAX_CHANNELS * MAX_EMB;
	localparam int WAW    = $clog2(WDEPTH);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_MAC   = 5'b00010,
		S_DRAIN = 5'b00100,
		S_MUL   = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	state_t state_q;
	logic [CIW-1:0] c_q;
	logic [EIW-1:0] e_q;
	logic [15:0]    rc_q;

	logic [7:0]  wmem [WDEPTH];
	logic [15:0] bmem [MAX_CHANNELS];
	logic [7:0]  rmem [MAX_EMB];

	logic signed [7:0]  w_s1;
	logic signed [7:0]  x_s1;
	logic signed [15:0] b_s1;
	logic               mac_v_s1;
	logic               first_s1;
	logic signed [31:0] acc_q;
	logic signed [31:0] prod_q;

	logic               issue;
	logic               we_w;
	logic               we_b;
	logic               we_r;
	logic [WAW-1:0]     w_wa;
	logic [WAW-1:0]     w_ra;
	logic               row_end;
	logic               e_last;
	logic               c_last;
	logic               out_free;
	logic [15:0]        rc_next;
	logic signed [15:0] mp;
	logic signed [31:0] shifted;
	logic signed [7:0]  clipped;

	assign pop    = (state_q == S_IDLE) && !q_empty;
	assign issue  = state_q == S_MAC;
	assign we_w   = pop && (cmd.op == i8lrq_pkg::ACT_WEIGHT);
	assign we_b   = pop && (cmd.op == i8lrq_pkg::ACT_BIAS);
	assign we_r   = pop && (cmd.op == i8lrq_pkg::ACT_ROW);
	assign row_end = we_r && cmd.trig;
	assign w_wa   = WAW'(int'(cmd.channel) * MAX_EMB + int'(cmd.emb_index));
	assign w_ra   = WAW'(int'(c_q) * MAX_EMB + int'(e_q));
	assign e_last = int'(e_q) == int'(elen) - 1;
	assign c_last = int'(c_q) == int'(nch) - 1;
	assign out_free = !result.valid || result.ready;

	// row counter wraps at seq_length, zero length acts as one
	always_comb begin
		if ((32'(rc_q) + 1) >= ((seq_length == '0) ? 32'd1 : 32'(seq_length))) begin
			rc_next = '0;
		end else begin
			rc_next = rc_q + 16'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (we_w) begin
			wmem[w_wa] <= cmd.value[7:0];
		end
		if (issue) begin
			w_s1 <= wmem[w_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (we_b) begin
			bmem[BAW'(cmd.channel)] <= cmd.value;
		end
		if (issue) begin
			b_s1 <= bmem[BAW'(c_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (we_r) begin
			rmem[EIW'(cmd.emb_index)] <= cmd.value[7:0];
		end
		if (issue) begin
			x_s1 <= rmem[e_q];
		end
	end

	assign mp = w_s1 * x_s1;

	// requantize: arithmetic shift then clip to int8
	always_comb begin
		shifted = prod_q >>> requant_shift;
		if (shifted > 32'(i8lrq_pkg::CLIP_MAX)) begin
			clipped = 8'(i8lrq_pkg::CLIP_MAX);
		end else if (shifted < 32'(i8lrq_pkg::CLIP_MIN)) begin
			clipped = 8'(i8lrq_pkg::CLIP_MIN);
		end else begin
			clipped = shifted[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_MUL) begin
			prod_q <= 32'(acc_q * 32'(scale_mul));
		end
		if ((state_q == S_OUT) && out_free) begin
			result.out_channel <= 6'(c_q);
			result.seq_pos     <= rc_q;
			result.out_value   <= clipped;
			result.last_of_row <= c_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			c_q          <= '0;
			e_q          <= '0;
			rc_q         <= '0;
			mac_v_s1     <= 1'b0;
			first_s1     <= 1'b0;
			acc_q        <= '0;
			result.valid <= 1'b0;
		end else begin
			mac_v_s1 <= issue;
			first_s1 <= issue && (e_q == '0);
			if (mac_v_s1) begin
				acc_q <= (first_s1 ? 32'(b_s1) : acc_q) + 32'(mp);
			end

			if ((state_q == S_OUT) && out_free) begin
				result.valid <= 1'b1;
			end else if (result.ready) begin
				result.valid <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (row_end) begin
						if (nch == '0) begin
							rc_q <= rc_next;
						end else begin
							c_q     <= '0;
							e_q     <= '0;
							state_q <= S_MAC;
						end
					end
				end
				S_MAC: begin
					if (e_last) begin
						state_q <= S_DRAIN;
					end else begin
						e_q <= e_q + 1'b1;
					end
				end
				S_DRAIN: state_q <= S_MUL;
				S_MUL:   state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						if (c_last) begin
							rc_q    <= rc_next;
							state_q <= S_IDLE;
						end else begin
							c_q     <= c_q + 1'b1;
							e_q     <= '0;
							state_q <= S_MAC;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[design/int8_linear_requant_top.sv]
// ----------------------------------------------------------------------------
// int8_linear_requant_top
// quantized linear projection with int8 requantized outputs
// ----------------------------------------------------------------------------
// item channel carries weight loads, bias loads and activation elements.
// a front stage drops out-of-range beats and flags the row end, a four-entry
// queue decouples it from the back, which writes the stores and runs the
// dot products. a load or a non-final activation is popped and stored while
// the back is idle. the final element of a row starts, per channel, one mac
// per cycle over the effective embedding positions, then drain, multiply and
// clip steps, limited by the single mac unit and the one-read-per-cycle
// weight memory. the back pops no further beat until the last channel's
// result is registered. results leave through a registered result channel
// in channel order; a stalled receiver holds the back, while the front keeps
// taking beats until the queue fills. config is written through
// cfg_we/cfg_idx/cfg_wdata; the user must write it only while idle, as the
// block does not enforce it. reset clears control and config to defaults;
// weight, bias and row stores are undefined until written and get no
// clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "int8_linear_requant_top_macros.svh"
module int8_linear_requant_top #(
	parameter int MAX_CHANNELS = i8lrq_pkg::MAX_CHANNELS_DEF,
	parameter int MAX_EMB      = i8lrq_pkg::MAX_EMB_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire [i8lrq_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire [i8lrq_pkg::CFG_W-1:0]       cfg_wdata,
	i8lrq_in_if.sink                         item,
	i8lrq_out_if.source                      result
);
	localparam int CH_CAP = (MAX_CHANNELS < i8lrq_pkg::RESULT_CAP) ?
		MAX_CHANNELS : i8lrq_pkg::RESULT_CAP;
	localparam int EW     = $clog2(MAX_EMB + 1);
	localparam int NW     = $clog2(CH_CAP + 1);

	logic [8:0]         emb_length_q;
	logic [6:0]         head_count_q;
	logic [6:0]         proj_count_q;
	logic [15:0]        seq_length_q;
	logic signed [15:0] scale_mul_q;
	logic [4:0]         requant_shift_q;

	logic [EW-1:0]      elen;
	logic [13:0]        nch_full;
	logic [NW-1:0]      nch;
	logic [5:0]         last_ch;

	logic               push;
	i8lrq_pkg::cmd_t    push_cmd;
	i8lrq_pkg::cmd_t    head;
	i8lrq_pkg::q_stat_t q_stat;
	logic               pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emb_length_q    <= 9'd256;
			head_count_q    <= 7'd1;
			proj_count_q    <= 7'd64;
			seq_length_q    <= 16'd1;
			scale_mul_q     <= 16'sd1;
			requant_shift_q <= 5'd0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				i8lrq_pkg::REG_EMB_LENGTH:    emb_length_q    <= cfg_wdata[8:0];
				i8lrq_pkg::REG_HEAD_COUNT:    head_count_q    <= cfg_wdata[6:0];
				i8lrq_pkg::REG_PROJ_COUNT:    proj_count_q    <= cfg_wdata[6:0];
				i8lrq_pkg::REG_SEQ_LENGTH:    seq_length_q    <= cfg_wdata;
				i8lrq_pkg::REG_SCALE_MUL:     scale_mul_q     <= cfg_wdata;
				i8lrq_pkg::REG_REQUANT_SHIFT: requant_shift_q <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	// effective embedding length: zero acts as one, saturates at MAX_EMB
	always_comb begin
		if (emb_length_q == '0) begin
			elen = EW'(1);
		end else if (int'(emb_length_q) > MAX_EMB) begin
			elen = EW'(MAX_EMB);
		end else begin
			elen = EW'(emb_length_q);
		end
	end

	assign nch_full = head_count_q * proj_count_q;
	assign nch = (int'(nch_full) > CH_CAP) ? NW'(CH_CAP) : NW'(nch_full);
	assign last_ch = 6'(int'(nch) - 1);

	i8lrq_front #(
		.MAX_CHANNELS(MAX_CHANNELS),
		.MAX_EMB     (MAX_EMB),
		.EW          (EW)
	) u_front (
		.item  (item),
		.elen  (elen),
		.q_stat(q_stat),
		.push  (push),
		.cmd   (push_cmd)
	);

	i8lrq_queue #(
		.DEPTH(i8lrq_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.stat    (q_stat)
	);

	i8lrq_back #(
		.MAX_CHANNELS(MAX_CHANNELS),
		.MAX_EMB     (MAX_EMB),
		.EW          (EW),
		.NW          (NW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (head),
		.q_empty      (q_stat.empty),
		.pop          (pop),
		.elen         (elen),
		.nch          (nch),
		.seq_length   (seq_length_q),
		.scale_mul    (scale_mul_q),
		.requant_shift(requant_shift_q),
		.result       (result)
	);

	`REQ_ASSERT(a_no_accept_when_full, q_stat.full |-> !item.ready, "item taken while full")
	`REQ_ASSERT(a_last_is_final_channel, result.valid && result.last_of_row |-> result.out_channel == last_ch, "bad last_of_row")
	`REQ_ASSERT(a_pop_needs_entry, pop |-> !q_stat.empty, "pop from empty queue")
	`REQ_ASSERT_RST(a_quiet_in_reset, !arst_n |=> !result.valid, "result valid during reset")
endmodule
`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the int8 linear requant block
// ----------------------------------------------------------------------------
// biases, the weights that later rows read and the first row positions are
// preloaded so that no row end reads an unwritten entry. a short stimulus
// table with some hand-computed outputs runs next, then several config
// settings with random rows, loads and noise. every output beat is checked
// against an in-bench projection model. both channels idle in random bursts;
// one long receiver hold fills the block.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int CW          = i8lrq_pkg::CFG_W;
	localparam int N_STIM      = 18;
	localparam logic [1:0] A_WGT   = i8lrq_pkg::ACT_WEIGHT;
	localparam logic [1:0] A_BIAS  = i8lrq_pkg::ACT_BIAS;
	localparam logic [1:0] A_ROW   = i8lrq_pkg::ACT_ROW;
	localparam logic [1:0] A_NOISE = 2'd3;

	typedef struct {
		logic [5:0]        ch;
		logic [15:0]       pos;
		logic signed [7:0] val;
		logic              last;
	} proj_out_t;

	typedef struct {
		logic [1:0]  act;
		logic [5:0]  ch;
		logic [7:0]  ei;
		logic [15:0] val;
		bit          typed;
		int          v0;
		int          v1;
	} stim_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [i8lrq_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CW-1:0] cfg_wdata = '0;

	i8lrq_in_if item_ch();
	i8lrq_out_if res_ch();

	int8_linear_requant_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata), .item(item_ch), .result(res_ch)
	);

	always #5 clk = ~clk;

	// projection model state
	logic signed [7:0]  w_mem[64][256];
	logic signed [15:0] b_mem[64];
	logic signed [7:0]  row_mem[256];
	logic [15:0]        row_pos;
	logic [8:0]         m_emb;
	logic [6:0]         m_head, m_proj;
	logic [15:0]        m_seq;
	logic signed [15:0] m_mul;
	logic [4:0]         m_shift;

	proj_out_t expected_outs[$];
	int mismatches = 0;
	int cycles = 0;
	bit quiet = 0;
	bit rx_hold_req = 0;
	bit rx_hold_used = 0;
	int rx_hold = 0;
	int rx_gap = 0;
	int eff_emb;

	function automatic logic signed [7:0] requant(int c, int elen);
		int acc, prod, sh;
		acc = b_mem[c];
		for (int e = 0; e < elen; e++)
			acc += w_mem[c][e] * row_mem[e];
		prod = acc * int'(m_mul);
		sh = prod >>> m_shift;
		if (sh > i8lrq_pkg::CLIP_MAX) return 8'sh7f;
		if (sh < i8lrq_pkg::CLIP_MIN) return 8'sh80;
		return sh[7:0];
	endfunction

	// update model state for one accepted beat, queue any row outputs
	task automatic project(logic [1:0] act, logic [5:0] ch, logic [7:0] ei,
			logic [15:0] val);
		int elen, nch, sl;
		proj_out_t o;
		case (act)
		A_WGT: w_mem[ch][ei] = val[7:0];
		A_BIAS: b_mem[ch] = val;
		A_ROW: begin
			row_mem[ei] = val[7:0];
			elen = (m_emb == 0) ? 1 : (m_emb > 256 ? 256 : m_emb);
			if (ei == elen - 1) begin
				nch = m_head * m_proj;
				if (nch > i8lrq_pkg::RESULT_CAP) nch = i8lrq_pkg::RESULT_CAP;
				for (int c = 0; c < nch; c++) begin
					o.ch = 6'(c);
					o.pos = row_pos;
					o.val = requant(c, elen);
					o.last = (c + 1 == nch);
					expected_outs.push_back(o);
				end
				sl = (m_seq == 0) ? 1 : m_seq;
				row_pos = (row_pos + 1 >= sl) ? 16'd0 : row_pos + 16'd1;
			end
		end
		default: ;
		endcase
	endtask

	task automatic send(logic [1:0] act, logic [5:0] ch, logic [7:0] ei,
			logic [15:0] val);
		int gap;
		gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
		repeat (gap) begin
			@(negedge clk);
			item_ch.valid = 0;
		end
		@(negedge clk);
		item_ch.valid = 1;
		item_ch.action = act;
		item_ch.channel = ch;
		item_ch.emb_index = ei;
		item_ch.value = val;
		do @(posedge clk); while (!item_ch.ready);
		project(act, ch, ei, val);
	endtask

	task automatic drain();
		@(negedge clk);
		item_ch.valid = 0;
		while (expected_outs.size() != 0) @(posedge clk);
		// loads still in the queue produce nothing; let them retire
		repeat (24) @(posedge clk);
	endtask

	task automatic set_regs(int emb, int head, int proj, int seq, int mul,
			int shift);
		logic [CW-1:0] vals[6];
		vals = '{CW'(emb), CW'(head), CW'(proj), CW'(seq), CW'(mul), CW'(shift)};
		for (int i = 0; i < 6; i++) begin
			@(negedge clk);
			cfg_we = 1;
			cfg_idx = i8lrq_pkg::reg_idx_t'(i);
			cfg_wdata = vals[i];
		end
		@(negedge clk);
		cfg_we = 0;
		m_emb = 9'(emb);
		m_head = 7'(head);
		m_proj = 7'(proj);
		m_seq = 16'(seq);
		m_mul = 16'(mul);
		m_shift = 5'(shift);
		eff_emb = (m_emb == 0) ? 1 : ((m_emb > 256) ? 256 : int'(m_emb));
	endtask

	// random rows with loads and noise between them
	task automatic run_rows(int rows);
		int r;
		for (int n = 0; n < rows; n++) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				send(A_WGT, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
					16'($urandom_range(0, 65535)));
			else if (r == 1)
				send(A_BIAS, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
					16'($urandom_range(0, 65535)));
			else if (r == 2)
				send(A_NOISE, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
					16'($urandom_range(0, 65535)));
			else if (r == 3 && eff_emb < 256)
				send(A_ROW, 6'($urandom_range(0, 63)), 8'($urandom_range(eff_emb, 255)),
					16'($urandom_range(0, 65535)));
			// stale entries: some positions skipped before the row end
			for (int e = 0; e < eff_emb; e++)
				if (e == eff_emb - 1 || $urandom_range(0, 9) != 0)
					send(A_ROW, 6'($urandom_range(0, 63)), 8'(e),
						16'($urandom_range(0, 65535)));
		end
	endtask

	// receiver: random stall bursts, one long hold on request
	always @(negedge clk) begin
		if (rx_hold_req && !rx_hold_used) begin
			rx_hold = 400;
			rx_hold_used = 1;
		end
		if (rx_hold > 0) begin
			rx_hold--;
			res_ch.ready = 0;
		end else if (quiet) begin
			res_ch.ready = 1;
		end else if (rx_gap > 0) begin
			rx_gap--;
			res_ch.ready = 0;
		end else if ($urandom_range(0, 5) == 0) begin
			rx_gap = $urandom_range(0, 3);
			res_ch.ready = 0;
		end else begin
			res_ch.ready = 1;
		end
	end

	always @(posedge clk) begin
		proj_out_t w;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_outs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output beat ch=%0d pos=%0d val=%0d",
						res_ch.out_channel, res_ch.seq_pos, res_ch.out_value);
			end else begin
				w = expected_outs.pop_front();
				if (w.ch !== res_ch.out_channel || w.pos !== res_ch.seq_pos ||
						w.val !== res_ch.out_value || w.last !== res_ch.last_of_row) begin
					mismatches++;
					if (mismatches <= 10)
						$display("output mismatch: exp ch=%0d pos=%0d val=%0d last=%0d,",
							w.ch, w.pos, w.val, w.last,
							" got ch=%0d pos=%0d val=%0d last=%0d",
							res_ch.out_channel, res_ch.seq_pos, res_ch.out_value,
							res_ch.last_of_row);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	stim_row_t stim_tbl[N_STIM] = '{
		'{A_BIAS,   0, 0, 16'sd32767,  0, 0, 0},
		'{A_BIAS,   1, 0, 16'h8000,    0, 0, 0},
		'{A_WGT,    0, 0, 16'sd127,    0, 0, 0},
		'{A_WGT,    1, 0, -16'sd128,   0, 0, 0},
		'{A_ROW,    0, 0, 16'h0000,    1, 127, -128},
		'{A_ROW,    0, 0, 16'hff80,    1, 127, -128},
		'{A_BIAS,   0, 0, 16'sd5,      0, 0, 0},
		'{A_BIAS,   1, 0, -16'sd3,     0, 0, 0},
		// only the low byte of an activation counts
		'{A_ROW,    0, 0, 16'h1200,    1, 5, -3},
		'{A_ROW,    0, 0, 16'h7f01,    1, 127, -128},
		'{A_NOISE,  5, 0, 16'h0001,    0, 0, 0},
		'{A_WGT,    0, 0, 16'sd1,      0, 0, 0},
		'{A_WGT,    1, 0, -16'sd1,     0, 0, 0},
		'{A_ROW,    0, 0, 16'sd100,    1, 105, -103},
		'{A_ROW,    0, 200, 16'h00aa,  0, 0, 0},
		'{A_WGT,    63, 255, 16'hffff, 0, 0, 0},
		'{A_BIAS,   63, 0, 16'h8000,   0, 0, 0},
		'{A_ROW,    9, 0, -16'sd1,     0, 0, 0}
	};

	initial begin
		int base;
		item_ch.valid = 0;
		item_ch.action = '0;
		item_ch.channel = '0;
		item_ch.emb_index = '0;
		item_ch.value = '0;
		row_pos = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// preload with no channels, so the row end of the fill emits nothing
		set_regs(8, 0, 1, 1, 1, 0);
		for (int c = 0; c < 64; c++)
			send(A_BIAS, 6'(c), 8'd0, 16'($urandom_range(0, 65535)));
		for (int c = 0; c < 64; c++)
			send(A_WGT, 6'(c), 8'd0, 16'($urandom_range(0, 65535)));
		for (int c = 0; c < 4; c++)
			for (int e = 1; e < 8; e++)
				send(A_WGT, 6'(c), 8'(e), 16'($urandom_range(0, 65535)));
		for (int e = 0; e < 8; e++)
			send(A_ROW, 6'd0, 8'(e), 16'($urandom_range(0, 65535)));
		drain();

		set_regs(1, 1, 2, 3, 1, 0);
		foreach (stim_tbl[i]) begin
			send(stim_tbl[i].act, stim_tbl[i].ch, stim_tbl[i].ei, stim_tbl[i].val);
			if (stim_tbl[i].typed) begin
				base = expected_outs.size() - 2;
				expected_outs[base].val = 8'(stim_tbl[i].v0);
				expected_outs[base + 1].val = 8'(stim_tbl[i].v1);
			end
		end
		drain();

		set_regs(0, 127, 64, 0, 32767, 0);
		run_rows(3);
		drain();
		set_regs(8, 0, 5, 2, 3, 4);
		run_rows(3);
		drain();
		set_regs(5, 2, 2, 4, $urandom_range(0, 65535), $urandom_range(0, 31));
		run_rows(4);
		drain();
		set_regs(4, 1, 1, 65535, 16'h8000, 31);
		run_rows(2);
		drain();
		set_regs(2, 1, 1, 1, 16'hffff, 1);
		run_rows(2);
		drain();

		// long receiver hold while full rows keep coming
		set_regs(1, 1, 127, 5, 200, 6);
		rx_hold_req = 1;
		run_rows(4);
		drain();

		for (int p = 0; p < 7; p++) begin
			quiet = (p == 6);
			set_regs($urandom_range(1, 8), $urandom_range(0, 2), $urandom_range(0, 2),
				$urandom_range(0, 6), $urandom_range(0, 65535), $urandom_range(0, 20));
			run_rows(3);
			drain();
		end

		repeat (50) @(posedge clk);
		if (mismatches == 0 && expected_outs.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire

[files.f]
+incdir+design
design/i8lrq_pkg.sv
design/i8lrq_in_if.sv
design/i8lrq_out_if.sv
design/i8lrq_front.sv
design/i8lrq_queue.sv
design/i8lrq_back.sv
design/int8_linear_requant_top.sv
tb/tb.sv
